[rtl/core/idalloc_pkg.sv]
package idalloc_pkg;

    // Pool geometry
    localparam int NUM_IDS     = 1024;
    localparam int HANDLE_BITS = 32;
    localparam int ID_W        = $clog2(NUM_IDS);
    localparam int LINK_W      = ID_W + 1;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int HANDLE_W    = 32;

    // A link equal to the pool size is the nil link
    localparam logic [LINK_W-1:0] LINK_NIL  = LINK_W'(NUM_IDS);
    localparam logic [LINK_W-1:0] LINK_LAST = LINK_W'(NUM_IDS - 1);

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TAKE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REINIT  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IN_USE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NIL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the request on an input transfer
        logic read;      // read all tables at the target id
        logic exec;      // decide, write links / flags, compute result
        logic append;    // second write of a release: link old tail
        logic sweep;     // write one entry of the rebuilt list
        logic deliver;   // move the result into the output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_reinit;
        logic do_free;
        logic sweep_last;
    } dp_status_t;

endpackage

[rtl/core/idalloc_ctrl.sv]
module idalloc_ctrl
    import idalloc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t dp_st,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_SWEEP_RST,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_APPEND,
        S_SWEEP_CMD,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Commands decoded from the current state
    always_comb begin
        cmd         = '0;
        cmd.capture = (state_reg == S_IDLE) && s_valid;
        cmd.read    = (state_reg == S_READ);
        cmd.exec    = (state_reg == S_EXEC);
        cmd.append  = (state_reg == S_APPEND);
        cmd.sweep   = (state_reg == S_SWEEP_RST) || (state_reg == S_SWEEP_CMD);
        cmd.deliver = (state_reg == S_DONE) && out_free;
    end

    // Next state and output valid
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_SWEEP_RST: begin
                if (dp_st.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (dp_st.is_reinit) begin
                    state_next = S_SWEEP_CMD;
                end else if (dp_st.do_free) begin
                    state_next = S_APPEND;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_APPEND: begin
                state_next = S_DONE;
            end
            S_SWEEP_CMD: begin
                if (dp_st.sweep_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_SWEEP_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[rtl/core/idalloc_dp.sv]
module idalloc_dp
    import idalloc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          dp_st,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [ID_W-1:0]     s_id,
    input  logic                s_id_is_nil,
    input  logic [HANDLE_W-1:0] s_handle,
    output logic [STATUS_W-1:0] m_status,
    output logic [ID_W-1:0]     m_id_out,
    output logic [HANDLE_W-1:0] m_handle_out
);

    // Tables
    logic [LINK_W-1:0]      next_mem   [NUM_IDS];
    logic [LINK_W-1:0]      prev_mem   [NUM_IDS];
    logic                   used_mem   [NUM_IDS];
    logic [HANDLE_BITS-1:0] handle_mem [NUM_IDS];

    // Request registers
    logic [MODE_W-1:0]   mode_reg;
    logic [ID_W-1:0]     id_reg;
    logic                nil_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [ID_W-1:0]     addr_reg;

    // List ends and sweep counter
    logic [LINK_W-1:0] head_reg;
    logic [LINK_W-1:0] tail_reg;
    logic [ID_W-1:0]   sweep_cnt_reg;

    // Registered read data
    logic [LINK_W-1:0]      next_rd_reg;
    logic [LINK_W-1:0]      prev_rd_reg;
    logic                   used_rd_reg;
    logic [HANDLE_BITS-1:0] handle_rd_reg;

    // Result and output registers
    logic [STATUS_W-1:0] res_status_reg;
    logic [ID_W-1:0]     res_id_reg;
    logic [HANDLE_W-1:0] res_handle_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ID_W-1:0]     m_id_reg;
    logic [HANDLE_W-1:0] m_handle_reg;

    logic [ID_W-1:0]     rd_addr;
    logic                id_ok;
    logic                head_nil;
    logic                do_unlink;
    logic                do_free;
    logic [STATUS_W-1:0] res_status_next;
    logic [ID_W-1:0]     res_id_next;
    logic [HANDLE_W-1:0] res_handle_next;

    // Write ports
    logic                   next_we, prev_we, used_we, hdl_we;
    logic [ID_W-1:0]        next_wa, prev_wa, used_wa;
    logic [LINK_W-1:0]      next_wd, prev_wd;
    logic                   used_wd;

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= s_mode;
            id_reg     <= s_id;
            nil_reg    <= s_id_is_nil;
            handle_reg <= s_handle;
        end
    end

    // Allocate works on the head, every other mode on the given id
    assign rd_addr = (mode_reg == MODE_ALLOC) ? head_reg[ID_W-1:0] : id_reg;

    // Table reads
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            addr_reg      <= rd_addr;
            next_rd_reg   <= next_mem[rd_addr];
            prev_rd_reg   <= prev_mem[rd_addr];
            used_rd_reg   <= used_mem[rd_addr];
            handle_rd_reg <= handle_mem[rd_addr];
        end
    end

    // Decision and result
    assign id_ok     = {1'b0, id_reg} < LINK_NIL;
    assign head_nil  = (head_reg == LINK_NIL);
    assign do_unlink = ((mode_reg == MODE_ALLOC) && !head_nil) ||
                       ((mode_reg == MODE_TAKE) && !nil_reg && id_ok && !used_rd_reg);
    assign do_free   = (mode_reg == MODE_RELEASE) && !nil_reg && id_ok && used_rd_reg;

    always_comb begin
        res_status_next = ST_OK;
        res_id_next     = id_reg;
        res_handle_next = '0;
        case (mode_reg)
            MODE_ALLOC: begin
                if (head_nil) begin
                    res_status_next = ST_EMPTY;
                    res_id_next     = '0;
                end else begin
                    res_id_next = head_reg[ID_W-1:0];
                end
            end
            MODE_TAKE: begin
                if (nil_reg) begin
                    res_status_next = ST_NIL;
                end else if (!id_ok || used_rd_reg) begin
                    res_status_next = ST_IN_USE;
                end
            end
            MODE_RELEASE: begin
                if (nil_reg) begin
                    res_status_next = ST_NIL;
                end else if (!id_ok || !used_rd_reg) begin
                    res_status_next = ST_NOT_USED;
                end
            end
            MODE_LOOKUP: begin
                if (nil_reg) begin
                    res_status_next = ST_NIL;
                end else if (!id_ok || !used_rd_reg) begin
                    res_status_next = ST_NOT_USED;
                end else begin
                    res_handle_next = HANDLE_W'(handle_rd_reg);
                end
            end
            default: begin
                res_status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_handle_reg <= res_handle_next;
        end
        if (cmd.deliver) begin
            m_status_reg <= res_status_reg;
            m_id_reg     <= res_id_reg;
            m_handle_reg <= res_handle_reg;
        end
    end

    // Write port selection
    always_comb begin
        next_we = 1'b0;
        next_wa = sweep_cnt_reg;
        next_wd = {1'b0, sweep_cnt_reg} + LINK_W'(1);
        prev_we = 1'b0;
        prev_wa = sweep_cnt_reg;
        prev_wd = (sweep_cnt_reg == '0) ? LINK_NIL : ({1'b0, sweep_cnt_reg} - LINK_W'(1));
        used_we = 1'b0;
        used_wa = sweep_cnt_reg;
        used_wd = 1'b0;
        hdl_we  = 1'b0;
        if (cmd.sweep) begin
            next_we = 1'b1;
            prev_we = 1'b1;
            used_we = 1'b1;
        end else if (cmd.exec && do_unlink) begin
            // predecessor skips over the entry, successor points back past it
            next_we = (prev_rd_reg != LINK_NIL);
            next_wa = prev_rd_reg[ID_W-1:0];
            next_wd = next_rd_reg;
            prev_we = (next_rd_reg != LINK_NIL);
            prev_wa = next_rd_reg[ID_W-1:0];
            prev_wd = prev_rd_reg;
            used_we = 1'b1;
            used_wa = addr_reg;
            used_wd = 1'b1;
            hdl_we  = 1'b1;
        end else if (cmd.exec && do_free) begin
            // new tail entry
            next_we = 1'b1;
            next_wa = addr_reg;
            next_wd = LINK_NIL;
            prev_we = 1'b1;
            prev_wa = addr_reg;
            prev_wd = tail_reg;
            used_we = 1'b1;
            used_wa = addr_reg;
            used_wd = 1'b0;
        end else if (cmd.append) begin
            // old tail points forward to the released entry
            next_we = (tail_reg != LINK_NIL);
            next_wa = tail_reg[ID_W-1:0];
            next_wd = {1'b0, addr_reg};
        end
    end

    // Table writes
    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (used_we) begin
            used_mem[used_wa] <= used_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (hdl_we) begin
            handle_mem[addr_reg] <= handle_reg[HANDLE_BITS-1:0];
        end
    end

    // List ends and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= LINK_LAST;
            sweep_cnt_reg <= '0;
        end else begin
            if (cmd.sweep) begin
                sweep_cnt_reg <= sweep_cnt_reg + ID_W'(1);
            end
            if (cmd.exec && (mode_reg == MODE_REINIT)) begin
                head_reg      <= '0;
                tail_reg      <= LINK_LAST;
                sweep_cnt_reg <= '0;
            end else if (cmd.exec && do_unlink) begin
                if (prev_rd_reg == LINK_NIL) begin
                    head_reg <= next_rd_reg;
                end
                if (next_rd_reg == LINK_NIL) begin
                    tail_reg <= prev_rd_reg;
                end
            end else if (cmd.append) begin
                if (tail_reg == LINK_NIL) begin
                    head_reg <= {1'b0, addr_reg};
                end
                tail_reg <= {1'b0, addr_reg};
            end
        end
    end

    assign dp_st.is_reinit  = (mode_reg == MODE_REINIT);
    assign dp_st.do_free    = do_free;
    assign dp_st.sweep_last = ({1'b0, sweep_cnt_reg} == LINK_LAST);

    assign m_status     = m_status_reg;
    assign m_id_out     = m_id_reg;
    assign m_handle_out = m_handle_reg;

endmodule

[rtl/core/id_allocator_free_list.sv]
// ID allocator over a doubly linked free list of 1024 IDs, one result per
// request. After reset the block rebuilds the list (s_ready low). A
// reinitialize request repeats that pass before its result is valid.
// Allocate, take, lookup and the unused modes go through the read, execute
// and done states; a release adds an append state after execute. The link
// tables have one write port each, so an unlink is a read step and then a
// write step, and a release writes the next-link table twice. s_ready rises
// in the same cycle as m_valid for the result. One request is in flight
// at a time. A new one is taken while the previous result still waits in the
// output register.
module id_allocator_free_list
    import idalloc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [ID_W-1:0]     s_id,
    input  logic                s_id_is_nil,
    input  logic [HANDLE_W-1:0] s_handle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ID_W-1:0]     m_id_out,
    output logic [HANDLE_W-1:0] m_handle_out
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_st;

    idalloc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_st   (dp_st),
        .cmd     (cmd)
    );

    idalloc_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .dp_st        (dp_st),
        .s_mode       (s_mode),
        .s_id         (s_id),
        .s_id_is_nil  (s_id_is_nil),
        .s_handle     (s_handle),
        .m_status     (m_status),
        .m_id_out     (m_id_out),
        .m_handle_out (m_handle_out)
    );

endmodule

[bench/id_allocator_free_list_tb.sv]
`timescale 1ns / 1ps

module id_allocator_free_list_tb;
    import idalloc_pkg::*;

    // Unused mode encodings; the block answers them as a no-op
    localparam logic [MODE_W-1:0] MODE_BAD_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAD_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_BAD_HI  = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id_out;
        logic [HANDLE_W-1:0] handle_out;
    } reply_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [ID_W-1:0]     id;
        logic                nil;
        logic [HANDLE_W-1:0] handle;
        logic                typed;    // reply below is fixed, else predicted
        reply_t              want;
    } req_row_t;

    localparam int DIRECTED_ROWS = 25;

    // Opening sequence, starting from the freshly built list 0..1023
    localparam req_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_LOOKUP,  10'd0,    1'b0, 32'h0,         1'b1, '{ST_NOT_USED, 10'd0,    32'h0}},
        '{MODE_RELEASE, 10'd1023, 1'b0, 32'h0,         1'b1, '{ST_NOT_USED, 10'd1023, 32'h0}},
        '{MODE_TAKE,    10'd5,    1'b1, 32'h0,         1'b1, '{ST_NIL,      10'd5,    32'h0}},
        '{MODE_RELEASE, 10'd1023, 1'b1, 32'h0,         1'b1, '{ST_NIL,      10'd1023, 32'h0}},
        '{MODE_LOOKUP,  10'd0,    1'b1, 32'h0,         1'b1, '{ST_NIL,      10'd0,    32'h0}},
        '{MODE_ALLOC,   10'h3FF,  1'b1, 32'hFFFF_FFFF, 1'b1, '{ST_OK,       10'd0,    32'h0}},
        '{MODE_LOOKUP,  10'd0,    1'b0, 32'h0,         1'b1, '{ST_OK,       10'd0,    32'hFFFF_FFFF}},
        '{MODE_TAKE,    10'd1023, 1'b0, 32'h0,         1'b1, '{ST_OK,       10'd1023, 32'h0}},
        '{MODE_TAKE,    10'd1023, 1'b0, 32'h1234_5678, 1'b1, '{ST_IN_USE,   10'd1023, 32'h0}},
        '{MODE_LOOKUP,  10'd1023, 1'b0, 32'h0,         1'b1, '{ST_OK,       10'd1023, 32'h0}},
        '{MODE_TAKE,    10'd512,  1'b0, 32'hA5A5_A5A5, 1'b0, '0},
        '{MODE_ALLOC,   10'd0,    1'b0, 32'h5A5A_5A5A, 1'b0, '0},
        '{MODE_TAKE,    10'd2,    1'b0, 32'h0F0F_0F0F, 1'b0, '0},
        '{MODE_RELEASE, 10'd0,    1'b0, 32'h0,         1'b0, '0},
        '{MODE_RELEASE, 10'd0,    1'b0, 32'h0,         1'b0, '0},
        '{MODE_LOOKUP,  10'd0,    1'b0, 32'h0,         1'b0, '0},
        '{MODE_LOOKUP,  10'd512,  1'b0, 32'h0,         1'b0, '0},
        '{MODE_BAD_LO,  10'h2AA,  1'b1, 32'h0,         1'b1, '{ST_OK,       10'h2AA,  32'h0}},
        '{MODE_BAD_MID, 10'h155,  1'b0, 32'hFFFF_FFFF, 1'b1, '{ST_OK,       10'h155,  32'h0}},
        '{MODE_BAD_HI,  10'h3FF,  1'b0, 32'hFFFF_FFFF, 1'b1, '{ST_OK,       10'h3FF,  32'h0}},
        '{MODE_REINIT,  10'h3FF,  1'b1, 32'hFFFF_FFFF, 1'b1, '{ST_OK,       10'h3FF,  32'h0}},
        '{MODE_LOOKUP,  10'd512,  1'b0, 32'h0,         1'b1, '{ST_NOT_USED, 10'd512,  32'h0}},
        '{MODE_ALLOC,   10'd7,    1'b0, 32'h8000_0001, 1'b1, '{ST_OK,       10'd0,    32'h0}},
        '{MODE_RELEASE, 10'd0,    1'b0, 32'h0,         1'b1, '{ST_OK,       10'd0,    32'h0}},
        '{MODE_ALLOC,   10'd0,    1'b0, 32'h7FFF_FFFE, 1'b0, '0}
    };

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [MODE_W-1:0]   s_mode = MODE_ALLOC;
    logic [ID_W-1:0]     s_id = '0;
    logic                s_id_is_nil = 1'b0;
    logic [HANDLE_W-1:0] s_handle = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [ID_W-1:0]     m_id_out;
    logic [HANDLE_W-1:0] m_handle_out;

    id_allocator_free_list dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_id         (s_id),
        .s_id_is_nil  (s_id_is_nil),
        .s_handle     (s_handle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_id_out     (m_id_out),
        .m_handle_out (m_handle_out)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Shadow copy of the pool: free list links, ownership, stored handles
    logic [LINK_W-1:0]   link_next [NUM_IDS];
    logic [LINK_W-1:0]   link_prev [NUM_IDS];
    logic [HANDLE_W-1:0] owner_handle [NUM_IDS];
    bit                  id_taken [NUM_IDS];
    logic [LINK_W-1:0]   list_head;
    logic [LINK_W-1:0]   list_tail;

    reply_t replies_due [$];
    int     mismatches = 0;
    bit     steady = 1'b0;     // no idling on either side while set
    int     stall_left = 0;

    function automatic void rebuild_pool();
        for (int i = 0; i < NUM_IDS; i++) begin
            link_prev[i] = (i == 0) ? LINK_NIL : LINK_W'(i - 1);
            link_next[i] = (i == NUM_IDS - 1) ? LINK_NIL : LINK_W'(i + 1);
            id_taken[i]  = 1'b0;
        end
        list_head = '0;
        list_tail = LINK_LAST;
    endfunction

    function automatic void unlink_id(input logic [ID_W-1:0] k);
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        p = link_prev[k];
        n = link_next[k];
        if (p != LINK_NIL) link_next[p[ID_W-1:0]] = n;
        else list_head = n;
        if (n != LINK_NIL) link_prev[n[ID_W-1:0]] = p;
        else list_tail = p;
        link_next[k] = LINK_NIL;
        link_prev[k] = LINK_NIL;
    endfunction

    // Next state of the pool and the reply for one request
    function automatic reply_t apply_request(input logic [MODE_W-1:0] mode,
                                             input logic [ID_W-1:0] id,
                                             input logic nil,
                                             input logic [HANDLE_W-1:0] handle);
        reply_t            r;
        logic [ID_W-1:0]   k;
        r.status     = ST_OK;
        r.id_out     = id;
        r.handle_out = '0;
        case (mode)
            MODE_ALLOC: begin
                if (list_head != LINK_NIL) begin
                    k = list_head[ID_W-1:0];
                    unlink_id(k);
                    id_taken[k]     = 1'b1;
                    owner_handle[k] = handle;
                    r.id_out        = k;
                end else begin
                    r.status = ST_EMPTY;
                    r.id_out = '0;
                end
            end
            MODE_TAKE: begin
                if (nil) r.status = ST_NIL;
                else if (id_taken[id]) r.status = ST_IN_USE;
                else begin
                    unlink_id(id);
                    id_taken[id]     = 1'b1;
                    owner_handle[id] = handle;
                end
            end
            MODE_RELEASE: begin
                if (nil) r.status = ST_NIL;
                else if (!id_taken[id]) r.status = ST_NOT_USED;
                else begin
                    // append at the tail; an empty list gets a new head too
                    id_taken[id]  = 1'b0;
                    link_prev[id] = list_tail;
                    link_next[id] = LINK_NIL;
                    if (list_tail != LINK_NIL) link_next[list_tail[ID_W-1:0]] = LINK_W'(id);
                    else list_head = LINK_W'(id);
                    list_tail = LINK_W'(id);
                end
            end
            MODE_LOOKUP: begin
                if (nil) r.status = ST_NIL;
                else if (!id_taken[id]) r.status = ST_NOT_USED;
                else r.handle_out = owner_handle[id];
            end
            MODE_REINIT: rebuild_pool();
            default: ;
        endcase
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random id that is in use (or free), or any id if there is none
    function automatic logic [ID_W-1:0] pick_id(input bit want_taken);
        int hits;
        int k;
        hits = 0;
        for (int i = 0; i < NUM_IDS; i++)
            if (id_taken[i] == want_taken) hits++;
        if (hits == 0) return ID_W'($urandom);
        k = $urandom_range(0, hits - 1);
        for (int i = 0; i < NUM_IDS; i++) begin
            if (id_taken[i] == want_taken) begin
                if (k == 0) return ID_W'(i);
                k--;
            end
        end
        return '0;
    endfunction

    // One input transfer; the reply is predicted at the accepting edge
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [ID_W-1:0] id,
                                input logic nil,
                                input logic [HANDLE_W-1:0] handle,
                                input logic typed,
                                input reply_t want);
        int     gap;
        reply_t predicted;
        gap = steady ? 0 : idle_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_id        <= id;
        s_id_is_nil <= nil;
        s_handle    <= handle;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(mode, id, nil, handle);
        replies_due.push_back(typed ? want : predicted);
    endtask

    task automatic send_random(input int alloc_pct);
        int                r;
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   id;
        r    = $urandom_range(0, 99);
        id   = ID_W'($urandom);
        mode = MODE_ALLOC;
        if (r < alloc_pct) mode = MODE_ALLOC;
        else if (r < alloc_pct + 10) begin
            mode = MODE_TAKE;
            id   = pick_id($urandom_range(0, 4) == 0);
        end else if (r < 70) begin
            mode = MODE_RELEASE;
            id   = pick_id($urandom_range(0, 6) != 0);
        end else if (r < 95) begin
            mode = MODE_LOOKUP;
            id   = pick_id($urandom_range(0, 4) != 0);
        end else if (r < 98) mode = MODE_BAD_LO + MODE_W'($urandom_range(0, 2));
        else if (r == 98) mode = MODE_REINIT;
        send_request(mode, id, $urandom_range(0, 19) == 0, $urandom, 1'b0, '0);
    endtask

    // Lower valid and hold off until every reply is back
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, short bursts mostly
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left <= idle_len();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest predicted reply
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $error("result with no request pending: status %0d id %0d handle %h",
                       m_status, m_id_out, m_handle_out);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    mismatches++;
                end
                if (m_id_out !== want.id_out) begin
                    $error("id_out: expected %0d, got %0d", want.id_out, m_id_out);
                    mismatches++;
                end
                if (m_handle_out !== want.handle_out) begin
                    $error("handle_out: expected %h, got %h", want.handle_out, m_handle_out);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        rebuild_pool();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(DIRECTED[i].mode, DIRECTED[i].id, DIRECTED[i].nil,
                         DIRECTED[i].handle, DIRECTED[i].typed, DIRECTED[i].want);

        // Start the random part from a freshly built list
        send_request(MODE_REINIT, '0, 1'b0, '0, 1'b0, '0);

        // Random traffic, back to back first, then with gaps on both sides
        steady = 1'b1;
        repeat (170) send_random(45);
        steady = 1'b0;
        repeat (170) send_random(30);
        wait_quiet();
        repeat (170) send_random(20);
        repeat (170) send_random(35);

        wait_quiet();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("id_allocator_free_list test passed");
        end else begin
            $display("id_allocator_free_list test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("id_allocator_free_list test failed");
        $finish;
    end

endmodule
